[sv/rgcr_pkg.sv]
// shared types and constants for the rtt gradient cwnd reduction unit
package rgcr_pkg;

    localparam int CWND_W  = 20;
    localparam int LIM_W   = CWND_W + 1;
    localparam int ALLOW_W = 16;
    localparam int RTT_W   = 32;
    localparam int SAMP_W  = 25;
    localparam int SEQ_W   = 32;
    localparam int PROD_W  = CWND_W + RTT_W;
    localparam int STEP_W  = $clog2(PROD_W);
    localparam int IN_W    = 168;
    localparam int OUT_W   = 48;

    localparam logic [RTT_W-1:0] RTT_IDLE = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        OP_RTT   = 2'd0,
        OP_ACK   = 2'd1,
        OP_START = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    // last member sits in the lowest bits
    typedef struct packed {
        logic              reduction_complete;
        logic              request_cwr;
        logic              ssthresh_written;
        logic [CWND_W-1:0] ssthresh_out;
        logic              cwnd_updated;
        logic [CWND_W-1:0] cwnd_out;
    } t_result;

endpackage

[sv/rgcr_div.sv]
// one quotient bit per cycle restoring divider for the rtt gradient
module rgcr_div import rgcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [RTT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [PROD_W-1:0] r_dq, n_dq;
    logic [RTT_W-1:0]  r_rem, n_rem;
    logic [RTT_W-1:0]  r_dvs, n_dvs;
    logic [RTT_W:0]    w_trial;
    logic [RTT_W:0]    w_sub;
    logic              w_qbit;

    assign w_trial = {r_rem, r_dq[PROD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_qbit  = ~w_sub[RTT_W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dq   = r_dq;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(PROD_W - 1);
            n_dq   = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_dq  = {r_dq[PROD_W-2:0], w_qbit};
            n_rem = w_qbit ? w_sub[RTT_W-1:0] : w_trial[RTT_W-1:0];
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

[sv/rgcr_ctrl_unused_placeholder.sv]
// sequencer-free helper: saturating window arithmetic for the final step
module rgcr_win import rgcr_pkg::*; (
    input  logic [CWND_W-1:0]  i_cwnd,
    input  logic [ALLOW_W-1:0] i_allow,
    input  logic [PROD_W-1:0]  i_diff,
    output logic [CWND_W-1:0]  o_cwnd
);

    logic [LIM_W-1:0]  w_limit;
    logic [CWND_W-1:0] w_half;
    logic              w_over;
    logic [LIM_W-1:0]  w_cand;
    logic [CWND_W-1:0] w_low;

    assign w_limit = {1'b0, i_cwnd} + LIM_W'(i_allow);
    assign w_half  = i_cwnd >> 1;
    assign w_over  = i_diff > PROD_W'(w_limit);
    assign w_cand  = w_limit - i_diff[LIM_W-1:0];

    always_comb begin
        w_low = (w_cand > {1'b0, i_cwnd}) ? i_cwnd : w_cand[CWND_W-1:0];
        if (w_over || w_low < w_half) begin
            o_cwnd = w_half;
        end else begin
            o_cwnd = w_low;
        end
    end

endmodule

[sv/rtt_gradient_cwnd_reduction_unit.sv]
// Takes one event at a time on the slave stream and returns one result per event on the
// master stream. An rtt sample, a start or end of reduction, or an ack that does not open
// a new round passes the decode and done states before its result turns valid. An ack that
// opens a round with a zero gradient, that is with a zero base rtt or a latest rtt below the
// base, also passes the final state. Any other ack that opens a round goes through decode,
// multiply, divide, final and done. The product inflight*(latest-base) is formed in the
// decode state and registered. The 52-bit quotient by the base rtt then comes from a serial
// divider that settles one bit per cycle, started from the multiply state. The slave side
// is ready again in the cycle the result turns valid. A finished result waits in the output
// register while the next event is taken, and a stalled master side holds the sequencer only
// once a second result is ready.
module rtt_gradient_cwnd_reduction_unit import rgcr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ALLOW_W-1:0]  i_cfg_data,     // window_growth_allowance
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // rtt_us, cwnd_in, packets_in_flight, highest_sacked_seq, next_send_seq,
    // oldest_unacked_seq, ecn_enabled, zero fill
    input  logic [IN_W-1:0]     i_s_tdata,
    input  logic [1:0]          i_s_tuser,      // op
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // cwnd_out, cwnd_updated, ssthresh_out, ssthresh_written, request_cwr,
    // reduction_complete, zero fill
    output logic [OUT_W-1:0]    o_m_tdata
);

    t_state             r_state, n_state;
    t_op                r_op;
    logic [SAMP_W-1:0]  r_rtt;
    logic [CWND_W-1:0]  r_cwnd;
    logic [CWND_W-1:0]  r_inflight;
    logic [SEQ_W-1:0]   r_sacked;
    logic [SEQ_W-1:0]   r_nxt;
    logic [SEQ_W-1:0]   r_una;
    logic               r_ecn;
    logic [ALLOW_W-1:0] r_allow;
    logic [RTT_W-1:0]   r_base_rtt, n_base_rtt;
    logic [RTT_W-1:0]   r_latest_rtt, n_latest_rtt;
    logic [SEQ_W-1:0]   r_mark, n_mark;
    logic               r_zero, n_zero;
    logic [PROD_W-1:0]  r_prod;
    t_result            r_res, n_res;
    t_result            r_out;
    logic               r_out_valid, n_out_valid;

    logic               w_accept;
    logic               w_out_free;
    logic [RTT_W-1:0]   w_sample;
    logic [RTT_W-1:0]   w_base_eff;
    logic [SEQ_W-1:0]   w_seq_d;
    logic               w_round_go;
    logic               w_diff_zero;
    logic [RTT_W-1:0]   w_gap;
    logic [PROD_W-1:0]  w_prod;
    logic               w_div_start;
    logic               w_div_done;
    logic [PROD_W-1:0]  w_quot;
    logic [PROD_W-1:0]  w_diff;
    logic [CWND_W-1:0]  w_new_cwnd;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid & o_s_tready;
    assign w_out_free  = ~r_out_valid | i_m_tready;

    assign w_sample    = RTT_W'(r_rtt[SAMP_W-2:0]) + RTT_W'(1);
    assign w_base_eff  = (r_base_rtt == '0) ? RTT_IDLE : r_base_rtt;
    assign w_seq_d     = r_sacked - r_mark;
    assign w_round_go  = (r_op == OP_ACK) && (w_seq_d != '0) && !w_seq_d[SEQ_W-1];
    assign w_diff_zero = (r_base_rtt == '0) || (r_latest_rtt < r_base_rtt);
    assign w_gap       = r_latest_rtt - r_base_rtt;
    assign w_prod      = PROD_W'(r_inflight) * PROD_W'(w_gap);
    assign w_diff      = r_zero ? '0 : w_quot;

    rgcr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_base_rtt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    rgcr_win u_win (
        .i_cwnd  (r_cwnd),
        .i_allow (r_allow),
        .i_diff  (w_diff),
        .o_cwnd  (w_new_cwnd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_DECODE;
            S_DECODE: begin
                if (!w_round_go) begin
                    n_state = S_DONE;
                end else if (w_diff_zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DIV;
            S_DIV:    if (w_div_done) n_state = S_FIN;
            S_FIN:    n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready  = 1'b1;
            S_MUL:   w_div_start = 1'b1;
            default: begin
                o_s_tready  = 1'b0;
                w_div_start = 1'b0;
            end
        endcase
    end

    // event datapath
    always_comb begin
        n_base_rtt   = r_base_rtt;
        n_latest_rtt = r_latest_rtt;
        n_mark       = r_mark;
        n_zero       = r_zero;
        n_res        = r_res;
        if (r_state == S_DECODE) begin
            n_res          = '0;
            n_res.cwnd_out = r_cwnd;
            unique case (r_op)
                OP_RTT: begin
                    if (!r_rtt[SAMP_W-1]) begin
                        n_base_rtt   = (w_sample < w_base_eff) ? w_sample : w_base_eff;
                        n_latest_rtt = w_sample;
                    end
                end
                OP_ACK: begin
                    if (w_round_go) begin
                        n_mark = r_nxt;
                        n_zero = w_diff_zero;
                    end
                end
                OP_START: begin
                    n_mark            = r_una;
                    n_res.request_cwr = r_ecn;
                end
                OP_END: begin
                    n_res.ssthresh_out       = (r_cwnd == '0) ? '0 : r_cwnd - CWND_W'(1);
                    n_res.ssthresh_written   = 1'b1;
                    n_res.reduction_complete = 1'b1;
                    n_base_rtt               = RTT_IDLE;
                    n_latest_rtt             = RTT_IDLE;
                end
                default: n_res = r_res;
            endcase
        end else if (r_state == S_FIN) begin
            n_res.cwnd_out     = w_new_cwnd;
            n_res.cwnd_updated = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_allow      <= '0;
            r_base_rtt   <= '0;
            r_latest_rtt <= '0;
            r_mark       <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_base_rtt   <= n_base_rtt;
            r_latest_rtt <= n_latest_rtt;
            r_mark       <= n_mark;
            if (i_cfg_valid) begin
                r_allow <= i_cfg_data;
            end
        end
        if (w_accept) begin
            r_op       <= t_op'(i_s_tuser);
            r_rtt      <= i_s_tdata[24:0];
            r_cwnd     <= i_s_tdata[44:25];
            r_inflight <= i_s_tdata[64:45];
            r_sacked   <= i_s_tdata[96:65];
            r_nxt      <= i_s_tdata[128:97];
            r_una      <= i_s_tdata[160:129];
            r_ecn      <= i_s_tdata[161];
        end
        if (r_state == S_DECODE) begin
            r_prod <= w_prod;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
        r_zero <= n_zero;
        r_res  <= n_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - $bits(t_result))'(0), r_out};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_base_rtt[RTT_W-1] && !r_latest_rtt[RTT_W-1])
        else $error("rtt state above idle value");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DECODE)
        else $error("accepted event not decoded");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.ssthresh_written == r_out.reduction_complete)
                       && !(r_out.cwnd_updated && r_out.ssthresh_written))
        else $error("inconsistent result flags");

endmodule
